FILE: src/tidrf_pkg.sv
// Package for the row identifier range filter.
// Opcode and verdict codes, shared constants, bound result struct, id compare.
// No dependencies.
package tidrf_pkg;

    localparam logic [15:0] MAX_OFFSET      = 16'd2048;
    localparam logic [31:0] LAST_VALID_BLOCK = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_BOUND   = 2'd1,
        OP_CHECK   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        VERDICT_SKIP   = 2'd0,
        VERDICT_ACCEPT = 2'd1,
        VERDICT_END    = 2'd2
    } t_verdict;

    // normalized bound, already intersected against the current range
    typedef struct packed {
        logic        kill;   // bound makes the range dead until the next restart
        logic        take;   // bound narrows the range
        logic [31:0] blk;
        logic [15:0] off;
    } t_bound;

    // (ab,ao) strictly above (bb,bo), lexicographic
    function automatic logic id_gt(input logic [31:0] ab, input logic [15:0] ao,
                                   input logic [31:0] bb, input logic [15:0] bo);
        logic res;
        if (ab != bb) begin
            res = (ab > bb);
        end else begin
            res = (ao > bo);
        end
        return res;
    endfunction

endpackage

FILE: src/tuple_id_range_filter.sv
// Row identifier range filter, top level.
// Uses tidrf_pkg, tidrf_bound_norm and tidrf_row_check.
//
// Keeps one range [lower, upper] of (block, offset) row identifiers and
// processes three kinds of transaction: restart (whole table from
// (0,1) to (table_blocks-1, MAX_OFFSET), or dead if the table is empty),
// bound (normalize an exclusive bound by one step with block carry or
// borrow, then intersect by max/min; null or unrepresentable bounds kill
// the range, bounds on a dead range are ignored), and check (skip, accept
// or end of scan for one row). Every transaction yields exactly one result
// carrying the verdict (skip for non-check opcodes), the empty flag and the
// range after the step. Throughput is one transaction per cycle while the
// output is not stalled; a transaction passes the input register and then
// the result register, with the range update and classification in the
// single logic stage between them. table_blocks is sampled at each restart
// and may only be written while no transaction is in flight.
module tuple_id_range_filter
    import tidrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic        i_bound_is_upper,
    input  logic        i_bound_inclusive,
    input  logic        i_bound_is_null,
    input  logic [31:0] i_id_block,
    input  logic [15:0] i_id_offset,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    output logic        o_range_empty,
    output logic [31:0] o_start_block,
    output logic [15:0] o_start_offset,
    output logic [31:0] o_end_block,
    output logic [15:0] o_end_offset
);

    // configuration register
    logic [31:0] r_table_blocks;

    // input register
    logic        r_in_vld;
    logic [1:0]  r_opcode;
    logic        r_is_upper;
    logic        r_inclusive;
    logic        r_is_null;
    logic [31:0] r_blk;
    logic [15:0] r_off;

    // range state
    logic [31:0] r_lower_block, n_lower_block;
    logic [15:0] r_lower_offset, n_lower_offset;
    logic [31:0] r_upper_block, n_upper_block;
    logic [15:0] r_upper_offset, n_upper_offset;
    logic        r_dead, n_dead;

    // result register
    logic        r_out_vld;
    logic [1:0]  r_verdict;
    logic        r_empty;
    logic [31:0] r_start_block;
    logic [15:0] r_start_offset;
    logic [31:0] r_end_block;
    logic [15:0] r_end_offset;

    logic        advance;
    logic        in_take;
    logic        cur_empty;
    logic        n_empty;
    t_bound      bnd;
    t_verdict    chk_verdict;
    t_verdict    n_verdict;

    // result register frees up when empty or being drained this cycle
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign cur_empty = r_dead ||
                       id_gt(r_lower_block, r_lower_offset, r_upper_block, r_upper_offset);

    tidrf_bound_norm u_bound (
        .i_is_upper     (r_is_upper),
        .i_inclusive    (r_inclusive),
        .i_blk          (r_blk),
        .i_off          (r_off),
        .i_lower_block  (r_lower_block),
        .i_lower_offset (r_lower_offset),
        .i_upper_block  (r_upper_block),
        .i_upper_offset (r_upper_offset),
        .o_bound        (bnd)
    );

    tidrf_row_check u_check (
        .i_empty        (cur_empty),
        .i_blk          (r_blk),
        .i_off          (r_off),
        .i_lower_block  (r_lower_block),
        .i_lower_offset (r_lower_offset),
        .i_upper_block  (r_upper_block),
        .i_upper_offset (r_upper_offset),
        .o_verdict      (chk_verdict)
    );

    // range update for the transaction in the input register
    always_comb begin
        n_lower_block  = r_lower_block;
        n_lower_offset = r_lower_offset;
        n_upper_block  = r_upper_block;
        n_upper_offset = r_upper_offset;
        n_dead         = r_dead;
        n_verdict      = VERDICT_SKIP;
        case (r_opcode)
            OP_RESTART: begin
                if (r_table_blocks == 32'd0) begin
                    n_dead = 1'b1;
                end else begin
                    n_dead         = 1'b0;
                    n_lower_block  = 32'd0;
                    n_lower_offset = 16'd1;
                    n_upper_block  = r_table_blocks - 32'd1;
                    n_upper_offset = MAX_OFFSET;
                end
            end
            OP_BOUND: begin
                if (!r_dead) begin
                    if (r_is_null || bnd.kill) begin
                        n_dead = 1'b1;
                    end else if (bnd.take) begin
                        if (r_is_upper) begin
                            n_upper_block  = bnd.blk;
                            n_upper_offset = bnd.off;
                        end else begin
                            n_lower_block  = bnd.blk;
                            n_lower_offset = bnd.off;
                        end
                    end
                end
            end
            OP_CHECK: begin
                n_verdict = chk_verdict;
            end
            default: begin
                // unused opcode: no state change, verdict skip
            end
        endcase
        n_empty = n_dead ||
                  id_gt(n_lower_block, n_lower_offset, n_upper_block, n_upper_offset);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_blocks <= 32'd0;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_lower_block  <= 32'd0;
            r_lower_offset <= 16'd1;
            r_upper_block  <= 32'd0;
            r_upper_offset <= 16'd0;
            r_dead         <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_table_blocks <= i_cfg_data;
            end
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld      <= 1'b1;
                r_lower_block  <= n_lower_block;
                r_lower_offset <= n_lower_offset;
                r_upper_block  <= n_upper_block;
                r_upper_offset <= n_upper_offset;
                r_dead         <= n_dead;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode    <= i_opcode;
            r_is_upper  <= i_bound_is_upper;
            r_inclusive <= i_bound_inclusive;
            r_is_null   <= i_bound_is_null;
            r_blk       <= i_id_block;
            r_off       <= i_id_offset;
        end
        if (advance) begin
            r_verdict      <= n_verdict;
            r_empty        <= n_empty;
            r_start_block  <= n_lower_block;
            r_start_offset <= n_lower_offset;
            r_end_block    <= n_upper_block;
            r_end_offset   <= n_upper_offset;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_verdict      = r_verdict;
    assign o_range_empty  = r_empty;
    assign o_start_block  = r_start_block;
    assign o_start_offset = r_start_offset;
    assign o_end_block    = r_end_block;
    assign o_end_offset   = r_end_offset;

endmodule

FILE: src/tidrf_bound_norm.sv
// Bound normalization: turns a lower or upper bound into an inclusive one
// and decides whether it narrows the current range. Depends on tidrf_pkg.
module tidrf_bound_norm
    import tidrf_pkg::*;
(
    input  logic        i_is_upper,
    input  logic        i_inclusive,
    input  logic [31:0] i_blk,
    input  logic [15:0] i_off,
    input  logic [31:0] i_lower_block,
    input  logic [15:0] i_lower_offset,
    input  logic [31:0] i_upper_block,
    input  logic [15:0] i_upper_offset,
    output t_bound      o_bound
);

    logic        up_excl;
    logic [31:0] nb;
    logic [15:0] no;
    logic        kill;

    always_comb begin
        nb      = i_blk;
        no      = i_off;
        kill    = 1'b0;
        up_excl = !i_inclusive || (i_off == 16'd0);
        if (i_is_upper) begin
            if (up_excl) begin
                if (i_off == 16'd0) begin
                    if (i_blk == 32'd0) begin
                        kill = 1'b1;
                    end else begin
                        nb = i_blk - 32'd1;
                        no = MAX_OFFSET;
                    end
                end else begin
                    no = i_off - 16'd1;
                end
            end
        end else begin
            if (!i_inclusive) begin
                if (i_off >= MAX_OFFSET) begin
                    if (i_blk >= LAST_VALID_BLOCK) begin
                        kill = 1'b1;
                    end else begin
                        nb = i_blk + 32'd1;
                        no = 16'd1;
                    end
                end else begin
                    no = i_off + 16'd1;
                end
            end else if (i_off == 16'd0) begin
                no = 16'd1;
            end
        end

        o_bound.kill = kill;
        o_bound.blk  = nb;
        o_bound.off  = no;
        if (i_is_upper) begin
            o_bound.take = id_gt(i_upper_block, i_upper_offset, nb, no);
        end else begin
            o_bound.take = id_gt(nb, no, i_lower_block, i_lower_offset);
        end
    end

endmodule

FILE: src/tidrf_row_check.sv
// Row classifier: skip, accept or end of scan against the current range.
// Depends on tidrf_pkg.
module tidrf_row_check
    import tidrf_pkg::*;
(
    input  logic        i_empty,
    input  logic [31:0] i_blk,
    input  logic [15:0] i_off,
    input  logic [31:0] i_lower_block,
    input  logic [15:0] i_lower_offset,
    input  logic [31:0] i_upper_block,
    input  logic [15:0] i_upper_offset,
    output t_verdict    o_verdict
);

    always_comb begin
        if (i_empty) begin
            o_verdict = VERDICT_END;
        end else if (i_blk < i_lower_block) begin
            o_verdict = VERDICT_SKIP;
        end else if (i_blk > i_upper_block) begin
            o_verdict = VERDICT_END;
        end else if (i_blk == i_lower_block && i_off < i_lower_offset) begin
            o_verdict = VERDICT_SKIP;
        end else if (i_blk == i_upper_block && i_off > i_upper_offset) begin
            o_verdict = VERDICT_END;
        end else begin
            o_verdict = VERDICT_ACCEPT;
        end
    end

endmodule

FILE: src/tidrf_checker.sv
// Port-level checker for the row identifier range filter, with its bind.
// Depends on tidrf_pkg and tuple_id_range_filter.
module tidrf_checker
    import tidrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_verdict,
    input  logic        o_range_empty,
    input  logic [31:0] o_start_block,
    input  logic [31:0] o_end_block
);

    // no result comes out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict) &&
            $stable(o_start_block) && $stable(o_end_block))
        else $error("stalled result changed");

    // an empty range never accepts a row
    a_empty_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_empty |-> o_verdict != VERDICT_ACCEPT)
        else $error("accept on empty range");

    // a live range has its lower block at or below its upper block
    a_live_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_range_empty |-> o_start_block <= o_end_block)
        else $error("live range inverted");

    // unused verdict code never shows
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_verdict == VERDICT_SKIP || o_verdict == VERDICT_ACCEPT ||
            o_verdict == VERDICT_END)
        else $error("bad verdict code");

endmodule

bind tuple_id_range_filter tidrf_checker u_tidrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_verdict     (o_verdict),
    .o_range_empty (o_range_empty),
    .o_start_block (o_start_block),
    .o_end_block   (o_end_block)
);
